FILE: sv/scu_pkg.sv
// shared types and constants of the sine and cosine unit
package scu_pkg;

   // fixed-point formats
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int OUT_FRAC_BITS   = 30;
   localparam int WQ              = 31;

   // magnitude of the quadrant index fits in this many bits
   localparam int KMAG_W = 33 - ANGLE_FRAC_BITS;

   // working word of the polynomial datapath, signed Q31 with headroom
   typedef logic signed [32:0] word_type;

   // 2/pi in unsigned Q0.32 and pi/2 in Q60
   localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
   localparam logic [63:0] HALF_PI_Q60     = 64'h1921FB54442D1847;

   // one in Q31
   localparam word_type W_ONE = 33'sd2147483648;

   // polynomial coefficients in Q31, lowest order first
   localparam word_type SIN_COEF [6] = '{
      -33'sd357913941, 33'sd17895697, -33'sd426088, 33'sd5918, -33'sd54, 33'sd0
   };
   localparam word_type COS_COEF [6] = '{
      -33'sd1073741824, 33'sd89478485, -33'sd2982616, 33'sd53261, -33'sd592, 33'sd4
   };

endpackage

FILE: sv/sine_cosine_unit.sv
// sine and cosine of a fixed-point angle, pipelined
//
//   channel  direction  contents
//   req_     in         angle, signed Q15.16 radians
//   rsp_     out        sine and cosine, signed Q1.30
//
// 25 register stages, 0 to 24: one request enters per cycle when nothing
// stalls, and its result comes out of the last stage.
// Each stage holds while it is full and the stage after it cannot take its
// contents, so empty stages close up and a request is taken whenever any
// bubble is left in the pipeline. Reset only clears the stage valid bits.
module sine_cosine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] sine, [63:32] cosine
);

   localparam int STAGES = 25;
   localparam int F      = scu_pkg::ANGLE_FRAC_BITS;
   localparam int KW     = scu_pkg::KMAG_W;
   localparam int SH     = scu_pkg::WQ - scu_pkg::OUT_FRAC_BITS;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // q31 value to output format, rounded half away from zero and clamped
   function automatic logic [31:0] to_out(input scu_pkg::word_type v);
      logic [32:0] mag;
      logic [33:0] rnd;
      logic [33:0] o;
      mag = v[32] ? 33'(-v) : 33'(v);
      rnd = (34'(mag) + (34'd1 << (SH - 1))) >> SH;
      o   = (rnd > (34'd1 << scu_pkg::OUT_FRAC_BITS)) ?
            (34'd1 << scu_pkg::OUT_FRAC_BITS) : rnd;
      if (v[32]) begin
         o = -o;
      end
      return o[31:0];
   endfunction

   // stage control
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] en;

   assign en = ~v_ff | {rsp_tready, en[STAGES-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int j = 1; j < STAGES; j++) begin
            if (en[j]) begin
               v_ff[j] <= v_ff[j-1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[STAGES-1];

   // stage 0: angle magnitude and sign
   logic [31:0]      amag_in;
   logic [31:0]      amag_ff;
   logic [31:0]      a_ff [0:4];
   logic             aneg_ff [0:4];

   assign amag_in = req_tdata[31] ? (~req_tdata + 32'd1) : req_tdata;

   // stage 1: |angle| * 2/pi
   logic [63:0]      prod_in;
   logic [63:0]      prod_ff;

   assign prod_in = 64'(amag_ff) * 64'(scu_pkg::TWO_OVER_PI_Q32);

   // stage 2: rounded quadrant index and quadrant
   logic [63:0]      ksum;
   logic [KW-1:0]    kmag_in;
   logic [KW-1:0]    kmag_ff;
   logic [1:0]       q_in;
   logic [1:0]       q_ff [2:23];

   always_comb begin
      ksum    = prod_ff + (64'd1 << (F + 31));
      kmag_in = KW'(ksum >> (F + 32));
      q_in    = aneg_ff[1] ? (~kmag_in[1:0] + 2'd1) : kmag_in[1:0];
   end

   // stage 3: k * pi/2 in two partial products
   logic [KW+31:0]   plo_in;
   logic [KW+31:0]   phi_in;
   logic [KW+31:0]   plo_ff;
   logic [KW+31:0]   phi_ff;

   assign plo_in = (KW+32)'(kmag_ff) * (KW+32)'(scu_pkg::HALF_PI_Q60[31:0]);
   assign phi_in = (KW+32)'(kmag_ff) * (KW+32)'(scu_pkg::HALF_PI_Q60[63:32]);

   // stage 4: join partial products modulo 2^64
   logic [63:0]      pp_in;
   logic [63:0]      pp_ff;

   assign pp_in = 64'(plo_ff) + {phi_ff[31:0], 32'd0};

   // stage 5: remainder in q60
   logic [63:0]      ash;
   logic [63:0]      ru_in;
   logic [63:0]      ru_ff;

   always_comb begin
      ash   = {{32{a_ff[4][31]}}, a_ff[4]} << (60 - F);
      ru_in = aneg_ff[4] ? (ash + pp_ff) : (ash - pp_ff);
   end

   // stage 6: remainder magnitude
   logic             rneg_ff;
   logic [63:0]      rmag_in;
   logic [63:0]      rmag_ff;

   assign rmag_in = ru_ff[63] ? (~ru_ff + 64'd1) : ru_ff;

   // stage 7: remainder rounded to q31
   logic [32:0]       rr;
   scu_pkg::word_type r_in;
   scu_pkg::word_type r_ff [7:21];

   always_comb begin
      rr   = 33'((rmag_ff + (64'd1 << 28)) >> 29);
      r_in = rneg_ff ? -$signed(rr) : $signed(rr);
   end

   // front-end registers
   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff[0]    <= req_tdata;
         aneg_ff[0] <= req_tdata[31];
         amag_ff    <= amag_in;
      end
      for (int j = 1; j <= 4; j++) begin
         if (en[j]) begin
            a_ff[j]    <= a_ff[j-1];
            aneg_ff[j] <= aneg_ff[j-1];
         end
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         kmag_ff <= kmag_in;
      end
      if (en[3]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (en[4]) begin
         pp_ff <= pp_in;
      end
      if (en[5]) begin
         ru_ff <= ru_in;
      end
      if (en[6]) begin
         rneg_ff <= ru_ff[63];
         rmag_ff <= rmag_in;
      end
   end

   // stages 8 and 9: r squared
   scu_pkg::word_type r2_w;
   scu_pkg::word_type r2_ff [10:19];

   scu_wmul u_sq (
      .clock (clock),
      .en_a  (en[8]),
      .en_b  (en[9]),
      .x_a   (r_ff[7]),
      .y_a   (r_ff[7]),
      .c_a   ('0),
      .p_b   (r2_w)
   );

   // stages 10 to 19: horner steps for both polynomials side by side
   scu_pkg::word_type r2_src [0:5];
   scu_pkg::word_type ts_src [0:5];
   scu_pkg::word_type tc_src [0:5];

   assign r2_src[0] = r2_w;
   assign ts_src[0] = scu_pkg::SIN_COEF[5];
   assign tc_src[0] = scu_pkg::COS_COEF[5];

   genvar s;
   generate
      for (s = 0; s < 5; s++) begin : g_step
         assign r2_src[s+1] = r2_ff[11 + 2*s];

         scu_wmul u_sin (
            .clock (clock),
            .en_a  (en[10 + 2*s]),
            .en_b  (en[11 + 2*s]),
            .x_a   (r2_src[s]),
            .y_a   (ts_src[s]),
            .c_a   (scu_pkg::SIN_COEF[4 - s]),
            .p_b   (ts_src[s+1])
         );

         scu_wmul u_cos (
            .clock (clock),
            .en_a  (en[10 + 2*s]),
            .en_b  (en[11 + 2*s]),
            .x_a   (r2_src[s]),
            .y_a   (tc_src[s]),
            .c_a   (scu_pkg::COS_COEF[4 - s]),
            .p_b   (tc_src[s+1])
         );
      end
   endgenerate

   // stages 20 and 21: one plus r2 times the sums
   scu_pkg::word_type hs_w;
   scu_pkg::word_type hc_w;

   scu_wmul u_sin_fin (
      .clock (clock),
      .en_a  (en[20]),
      .en_b  (en[21]),
      .x_a   (r2_src[5]),
      .y_a   (ts_src[5]),
      .c_a   (scu_pkg::W_ONE),
      .p_b   (hs_w)
   );

   scu_wmul u_cos_fin (
      .clock (clock),
      .en_a  (en[20]),
      .en_b  (en[21]),
      .x_a   (r2_src[5]),
      .y_a   (tc_src[5]),
      .c_a   (scu_pkg::W_ONE),
      .p_b   (hc_w)
   );

   // stages 22 and 23: sine polynomial times r, cosine waits alongside
   scu_pkg::word_type sp_w;
   scu_pkg::word_type cp_ff [22:23];

   scu_wmul u_sin_r (
      .clock (clock),
      .en_a  (en[22]),
      .en_b  (en[23]),
      .x_a   (r_ff[21]),
      .y_a   (hs_w),
      .c_a   ('0),
      .p_b   (sp_w)
   );

   // side values that travel with the request
   always_ff @(posedge clock) begin
      if (en[2]) begin
         q_ff[2] <= q_in;
      end
      for (int j = 3; j <= 23; j++) begin
         if (en[j]) begin
            q_ff[j] <= q_ff[j-1];
         end
      end
      if (en[7]) begin
         r_ff[7] <= r_in;
      end
      for (int j = 8; j <= 21; j++) begin
         if (en[j]) begin
            r_ff[j] <= r_ff[j-1];
         end
      end
      if (en[10]) begin
         r2_ff[10] <= r2_w;
      end
      for (int j = 11; j <= 19; j++) begin
         if (en[j]) begin
            r2_ff[j] <= r2_ff[j-1];
         end
      end
      if (en[22]) begin
         cp_ff[22] <= hc_w;
      end
      if (en[23]) begin
         cp_ff[23] <= cp_ff[22];
      end
   end

   // stage 24: quadrant selection, output rounding and clamp
   scu_pkg::word_type s_sel;
   scu_pkg::word_type c_sel;
   logic [31:0]       sine_in;
   logic [31:0]       cosine_in;
   logic [31:0]       sine_ff;
   logic [31:0]       cosine_ff;

   always_comb begin
      unique case (q_ff[23])
         QUAD_0: begin
            s_sel = sp_w;
            c_sel = cp_ff[23];
         end
         QUAD_1: begin
            s_sel = cp_ff[23];
            c_sel = -sp_w;
         end
         QUAD_2: begin
            s_sel = -sp_w;
            c_sel = -cp_ff[23];
         end
         QUAD_3: begin
            s_sel = -cp_ff[23];
            c_sel = sp_w;
         end
         default: begin
            s_sel = sp_w;
            c_sel = cp_ff[23];
         end
      endcase
      sine_in   = to_out(s_sel);
      cosine_in = to_out(c_sel);
   end

   always_ff @(posedge clock) begin
      if (en[24]) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign rsp_tdata = {cosine_ff, sine_ff};

endmodule

FILE: sv/scu_wmul.sv
// two-stage q31 multiply with rounding half away from zero and an addend
module scu_wmul (
   input  logic                clock,
   input  logic                en_a,
   input  logic                en_b,
   input  scu_pkg::word_type   x_a,
   input  scu_pkg::word_type   y_a,
   input  scu_pkg::word_type   c_a,
   output scu_pkg::word_type   p_b
);

   logic                neg_in;
   logic [31:0]         xm;
   logic [31:0]         ym;
   logic [63:0]         prod_in;
   logic                neg_ff;
   logic [63:0]         prod_ff;
   scu_pkg::word_type   c_ff;
   logic [32:0]         m;
   scu_pkg::word_type   sm;
   scu_pkg::word_type   p_in;
   scu_pkg::word_type   p_ff;

   // stage a: magnitudes and their product
   always_comb begin
      xm      = x_a[32] ? 32'(-x_a) : 32'(x_a);
      ym      = y_a[32] ? 32'(-y_a) : 32'(y_a);
      neg_in  = x_a[32] ^ y_a[32];
      prod_in = 64'(xm) * 64'(ym);
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         neg_ff  <= neg_in;
         prod_ff <= prod_in;
         c_ff    <= c_a;
      end
   end

   // stage b: round back to q31, restore sign, add the coefficient
   always_comb begin
      m    = 33'((prod_ff + (64'd1 << (scu_pkg::WQ - 1))) >> scu_pkg::WQ);
      sm   = neg_ff ? -$signed(m) : $signed(m);
      p_in = c_ff + sm;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         p_ff <= p_in;
      end
   end

   assign p_b = p_ff;

endmodule

FILE: bench/tb_sine_cosine_unit.sv
// testbench for the sine and cosine unit: directed corners, random angles, scoreboard checks
`timescale 1ns / 1ps

module tb_sine_cosine_unit;

   // fixed-point formats and constants of the angle reduction
   localparam int AF = 16;                  // fraction bits of the angle
   localparam int OF = 30;                  // fraction bits of the results
   localparam int FQ = 31;                  // fraction bits of the polynomial datapath
   localparam bit [63:0] TWO_OVER_PI = 64'd2734261102;         // Q0.32
   localparam bit [63:0] HALF_PI     = 64'h1921FB54442D1847;   // Q60
   localparam longint UNIT_Q31 = 64'sd2147483648;

   localparam int RANDOM_ITEMS = 1150;
   localparam int LONG_HOLD    = 300;       // receiver stall that fills the pipeline
   localparam int SETTLE       = 40;        // beyond the 25 pipeline stages
   localparam int MAX_LINES    = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] angle
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [31:0] sine, [63:32] cosine

   logic quiet = 1'b0;            // no gaps on either side while set
   logic hold_burst = 1'b0;       // asks the receiver for one long stall
   int   stall_left = 0;

   // expected sine and cosine for one request
   typedef struct {
      logic [31:0] angle;
      logic [31:0] sine;
      logic [31:0] cosine;
   } trig_pair_type;

   class trig_ledger;
      trig_pair_type awaiting[$];
      int errors = 0;

      task report(string what);
         errors++;
         if (errors <= MAX_LINES)
            $display("mismatch at %0t: %s", $time, what);
      endtask

      function bit [63:0] mag(longint v);
         bit [63:0] u;
         u = v;
         return v < 0 ? 64'd0 - u : u;
      endfunction

      // Q31 product, rounded half away from zero on the magnitude
      function longint mul_q31(longint x, longint y);
         bit        neg;
         bit [63:0] p;
         longint    m;
         neg = (x < 0) != (y < 0);
         p = mag(x) * mag(y);
         m = longint'((p + (64'd1 << (FQ - 1))) >> FQ);
         return neg ? -m : m;
      endfunction

      function longint term(bit cos_set, int idx);
         case (idx)
            0: return cos_set ? -64'sd1073741824 : -64'sd357913941;
            1: return cos_set ? 64'sd89478485 : 64'sd17895697;
            2: return cos_set ? -64'sd2982616 : -64'sd426088;
            3: return cos_set ? 64'sd53261 : 64'sd5918;
            4: return cos_set ? -64'sd592 : -64'sd54;
            default: return cos_set ? 64'sd4 : 64'sd0;
         endcase
      endfunction

      // 1 + r2*(c0 + r2*(c1 + ...)) in Horner form
      function longint poly(bit cos_set, longint r2);
         longint t;
         t = term(cos_set, 5);
         for (int i = 4; i >= 0; i--)
            t = term(cos_set, i) + mul_q31(r2, t);
         return UNIT_Q31 + mul_q31(r2, t);
      endfunction

      // Q31 to the output format, rounded and clamped to +/-1.0
      function logic [31:0] to_out(longint v);
         bit [63:0] m;
         longint    o;
         m = mag(v);
         if (FQ > OF)
            m = (m + (64'd1 << (FQ - OF - 1))) >> (FQ - OF);
         o = longint'(m);
         if (o > (64'sd1 << OF))
            o = 64'sd1 << OF;
         if (v < 0)
            o = -o;
         return o[31:0];
      endfunction

      function trig_pair_type predict_sincos(logic [31:0] angle);
         trig_pair_type res;
         bit [63:0] a_u, amag, kmag, k_u, r_u, rmag;
         bit        aneg, rneg;
         bit [1:0]  quad;
         longint    r, r2, sp, cp, s, c;
         aneg = angle[31];
         a_u  = {{32{angle[31]}}, angle};
         amag = aneg ? 64'd0 - a_u : a_u;
         // nearest multiple of pi/2, halves away from zero
         kmag = (amag * TWO_OVER_PI + (64'd1 << (AF + 31))) >> (AF + 32);
         k_u  = aneg ? 64'd0 - kmag : kmag;
         quad = k_u[1:0];
         // remainder in Q60, then rounded to Q31
         r_u  = (a_u << (60 - AF)) - k_u * HALF_PI;
         rneg = r_u[63];
         rmag = rneg ? 64'd0 - r_u : r_u;
         r = longint'((rmag + (64'd1 << 28)) >> 29);
         if (rneg)
            r = -r;
         r2 = mul_q31(r, r);
         sp = mul_q31(r, poly(1'b0, r2));
         cp = poly(1'b1, r2);
         // quadrant picks polynomial and sign
         case (quad)
            2'd0: begin s = sp;  c = cp;  end
            2'd1: begin s = cp;  c = -sp; end
            2'd2: begin s = -sp; c = -cp; end
            default: begin s = -cp; c = sp; end
         endcase
         res.angle  = angle;
         res.sine   = to_out(s);
         res.cosine = to_out(c);
         return res;
      endfunction

      function void note_angle(logic [31:0] angle);
         awaiting.push_back(predict_sincos(angle));
      endfunction

      task check_result(logic [63:0] data);
         trig_pair_type want;
         if (awaiting.size() == 0) begin
            report($sformatf("result %h with no request outstanding", data));
         end else begin
            want = awaiting.pop_front();
            if (data[31:0] !== want.sine)
               report($sformatf("angle %h sine %h, want %h", want.angle, data[31:0],
                                want.sine));
            if (data[63:32] !== want.cosine)
               report($sformatf("angle %h cosine %h, want %h", want.angle, data[63:32],
                                want.cosine));
         end
      endtask

      function int pending();
         return awaiting.size();
      endfunction
   endclass

   trig_ledger ledger = new();

   sine_cosine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly no gap, often short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // full range, small angles, near multiples of pi/4, near the extremes
   function automatic logic [31:0] random_angle();
      int roll;
      int k;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return $urandom;
      if (roll < 7)
         return $urandom_range(0, 1647100) - 823550;
      if (roll < 9) begin
         k = $urandom_range(0, 64) - 32;
         return k * 51472 + ($urandom_range(0, 64) - 32);
      end
      if ($urandom_range(0, 1))
         return 32'h7FFFFFFF - $urandom_range(0, 255);
      return 32'h80000000 + $urandom_range(0, 255);
   endfunction

   // offer one request and hold it until taken
   task send_angle(logic [31:0] angle);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (!req_tready);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pauses until every result is back
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   // receiver with random stalls and one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_burst) begin
         hold_burst <= 1'b0;
         rsp_tready <= 1'b0;
         stall_left = LONG_HOLD;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet)
            stall_left = pick_gap();
      end
   end

   // note accepted requests, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            ledger.note_angle(req_tdata);
         if (rsp_tvalid && rsp_tready)
            ledger.check_result(rsp_tdata);
      end
   end

   // zero, unit steps, extremes, quarter and half turns, pi/4 boundaries
   localparam logic [31:0] CORNERS [23] = '{
      32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
      32'h00010000, 32'hFFFF0000, 32'd51471, 32'd51472, -32'sd51472,
      32'd102944, -32'sd102944, 32'd154415, 32'd154416, 32'd205887,
      -32'sd205887, 32'd308831, 32'd411775, 32'h40000000, 32'hC0000000,
      32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF
   };

   initial begin
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (CORNERS[i])
         send_angle(CORNERS[i]);
      drain();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
         // long receiver hold while requests keep coming back to back
         if (n == 430) begin
            quiet <= 1'b1;
            hold_burst <= 1'b1;
         end
         if (n == 800)
            drain();
         send_angle(random_angle());
      end

      drain();
      repeat (SETTLE) @(posedge clock);

      if (ledger.errors == 0)
         $display("tb_sine_cosine_unit: done, clean");
      else
         $display("tb_sine_cosine_unit: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb_sine_cosine_unit: done, errors");
      $finish;
   end

endmodule
